@@ sv/etdc_pkg.sv @@
// shared constants, types and lookup tables for the enveloped tanh distortion cascade
package etdc_pkg;

   localparam int SAMPLE_W        = 24;
   localparam int COEF_W          = 16;
   localparam int CSR_ADDR_W      = 1;
   localparam int STAGE_COUNT_DEF = 5;
   localparam int RATIO_DEPTH     = 16;
   localparam int RATIO_IDX_W     = 4;
   localparam int RATIO_W         = 16;
   localparam int GAIN_W          = 17;
   localparam int PMAG_W          = 28;
   localparam int MUL_A_W         = 28;
   localparam int MUL_B_W         = 24;
   localparam int PROD_W          = MUL_A_W + MUL_B_W;
   localparam int TANH_POINTS     = 33;
   localparam int TANH_IDX_W      = 5;
   localparam int TANH_ADDR_W     = 6;
   localparam int TANH_W          = 19;
   localparam int FRAC_W          = 16;
   localparam int ARG_W           = 34;
   localparam int OUT_MAX         = 524287;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_DRIVE_GAIN      = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STAGE_SMOOTHING = 1'd1;

   localparam logic [COEF_W-1:0] DRIVE_GAIN_RESET      = 16'd8192;
   localparam logic [COEF_W-1:0] STAGE_SMOOTHING_RESET = 16'd65470;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [COEF_W-1:0]          coef_type;

   // operand request to the shared multiplier
   typedef struct packed {
      logic               load;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   // fibonacci ratios in unsigned q2.14, 55/34 first, golden ratio past the series
   localparam logic [RATIO_W-1:0] RATIO_ROM [RATIO_DEPTH] = '{
      16'd26504, 16'd26512, 16'd26509, 16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510,
      16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510
   };

   // tanh over [0,4] in steps of 1/8, q.19
   localparam logic [TANH_W-1:0] TANH_TABLE [TANH_POINTS] = '{
      19'd0,      19'd65197,  19'd128408, 19'd187882, 19'd242282, 19'd290770,
      19'd333001, 19'd369049, 19'd399295, 19'd424307, 19'd444745, 19'd461283,
      19'd474558, 19'd485148, 19'd493552, 19'd500194, 19'd505428, 19'd509541,
      19'd512767, 19'd515294, 19'd517270, 19'd518814, 19'd520020, 19'd520961,
      19'd521695, 19'd522268, 19'd522714, 19'd523062, 19'd523333, 19'd523544,
      19'd523708, 19'd523837, 19'd523936
   };

   function automatic logic [RATIO_W-1:0] ratio_at(input logic [RATIO_IDX_W-1:0] idx);
      return RATIO_ROM[idx];
   endfunction

   function automatic logic [TANH_W-1:0] tanh_at(input logic [TANH_ADDR_W-1:0] idx);
      logic [TANH_W-1:0] val;
      if (idx >= TANH_ADDR_W'(TANH_POINTS)) begin
         val = TANH_TABLE[TANH_POINTS-1];
      end else begin
         val = TANH_TABLE[idx];
      end
      return val;
   endfunction

endpackage

@@ sv/etdc_channels.sv @@
// request and response word channels of the distortion cascade
interface etdc_req_if;
   import etdc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface etdc_rsp_if;
   import etdc_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

@@ sv/enveloped_tanh_distortion_cascade.sv @@
// top level of the enveloped tanh distortion cascade
//
// usage
//   req carries one signed q4.19 audio word; rsp returns one distorted q4.19 word
//   per request word, in order. both channels use valid/ready; a word moves on a
//   rising clock edge with valid and ready high.
//   csr_we/csr_addr/csr_wdata write drive_gain (index 0) and stage_smoothing
//   (index 1); write only while no word is in flight.
// sequencing
//   each word walks the stages one after another through a single shared
//   multiplier, through the states S_ENV_A to S_TAN_C in each stage (envelope,
//   gain, product, tanh lookup and interpolation), then waits in S_DONE until
//   the output register is free. req.ready is high only while the sequencer is
//   idle, so a new word is accepted only once the previous one has left S_DONE.
// reset
//   synchronous, active high: envelopes cleared, registers to their defaults,
//   output register emptied.
// backpressure
//   the result sits in an output register; a new word is accepted while it waits.
//   a finished word that finds the output register still full holds until rsp.ready.
module enveloped_tanh_distortion_cascade #(
   parameter int STAGE_COUNT = etdc_pkg::STAGE_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   etdc_req_if.sink                         req,
   etdc_rsp_if.source                       rsp,
   input  logic                             csr_we,
   input  logic [etdc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [etdc_pkg::COEF_W-1:0]      csr_wdata
);
   import etdc_pkg::*;

   localparam int STAGE_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
   localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(STAGE_COUNT - 1);

   // sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ENV_A = 4'd1;
   localparam logic [3:0] S_ENV_B = 4'd2;
   localparam logic [3:0] S_ENV_C = 4'd3;
   localparam logic [3:0] S_GAIN  = 4'd4;
   localparam logic [3:0] S_PROD  = 4'd5;
   localparam logic [3:0] S_ARG   = 4'd6;
   localparam logic [3:0] S_TAN_A = 4'd7;
   localparam logic [3:0] S_TAN_B = 4'd8;
   localparam logic [3:0] S_TAN_C = 4'd9;
   localparam logic [3:0] S_DONE  = 4'd10;

   localparam sample_type OUT_POS = SAMPLE_W'(OUT_MAX);
   localparam sample_type OUT_NEG = -OUT_POS;

   // control state
   logic [3:0]         state_ff, state_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic               rsp_valid_ff, rsp_valid_in;
   coef_type           drive_ff, smooth_ff;
   logic [SAMPLE_W-1:0] env_ff [STAGE_COUNT];

   // datapath
   logic [SAMPLE_W-1:0] mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;
   logic [SAMPLE_W-1:0] env_cur_ff, env_cur_in;
   logic [GAIN_W-1:0]   g_ff, g_in;
   logic [PMAG_W-1:0]   p_ff, p_in;
   logic                sat_ff, sat_in;
   logic [TANH_IDX_W-1:0] idx_ff, idx_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   sample_type          rsp_data_ff, rsp_data_in;

   logic                env_we;
   logic [SAMPLE_W-1:0] env_new;
   logic [PROD_W:0]     env_sum;
   logic [32:0]         g_sum;
   logic [47:0]         p_sum;
   logic [ARG_W-1:0]    arg_sum;
   logic [32:0]         interp_sum;
   logic [TANH_W-1:0]   tanh_lo, tanh_hi;
   logic [PROD_W-1:0]   prod;
   mul_req_type         mul_req;
   logic                out_free;

   etdc_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

   // rounding of each product back to its working format
   assign env_sum    = {1'b0, acc_ff} + {1'b0, prod} + (PROD_W+1)'(32768);
   assign env_new    = env_sum[39:16];
   assign g_sum      = prod[32:0] + 33'd8192;
   assign p_sum      = prod[47:0] + 48'd262144;
   // q.32 product rounded to nearest into the q.19 tanh argument
   assign arg_sum    = ARG_W'((prod[45:0] + 46'd4096) >> 13);
   assign interp_sum = prod[32:0] + 33'd32768;
   assign tanh_lo    = tanh_at({1'b0, idx_ff});
   assign tanh_hi    = tanh_at({1'b0, idx_ff} + 6'd1);
   assign out_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      env_cur_in   = env_cur_ff;
      g_in         = g_ff;
      p_in         = p_ff;
      sat_in       = sat_ff;
      idx_in       = idx_ff;
      frac_in      = frac_ff;
      env_we       = 1'b0;
      mul_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               // negation of the most negative word gives 2^23, which still fits
               neg_in   = req.sample_in[SAMPLE_W-1];
               mag_in   = req.sample_in[SAMPLE_W-1] ? -req.sample_in : req.sample_in;
               stage_in = '0;
               state_in = S_ENV_A;
            end
         end
         S_ENV_A: begin
            mul_req.load = 1'b1;
            mul_req.a    = MUL_A_W'(smooth_ff);
            mul_req.b    = env_ff[stage_ff];
            state_in     = S_ENV_B;
         end
         S_ENV_B: begin
            acc_in       = prod;
            mul_req.load = 1'b1;
            mul_req.a    = MUL_A_W'(17'h10000 - {1'b0, smooth_ff});
            mul_req.b    = mag_ff;
            state_in     = S_ENV_C;
         end
         S_ENV_C: begin
            env_we       = 1'b1;
            env_cur_in   = env_new;
            mul_req.load = 1'b1;
            mul_req.a    = MUL_A_W'(drive_ff);
            mul_req.b    = MUL_B_W'(ratio_at(RATIO_IDX_W'(stage_ff)));
            state_in     = S_GAIN;
         end
         S_GAIN: begin
            g_in         = g_sum[30:14];
            mul_req.load = 1'b1;
            mul_req.a    = MUL_A_W'(env_cur_ff);
            mul_req.b    = mag_ff;
            state_in     = S_PROD;
         end
         S_PROD: begin
            p_in     = p_sum[46:19];
            state_in = S_ARG;
         end
         S_ARG: begin
            mul_req.load = 1'b1;
            mul_req.a    = p_ff;
            mul_req.b    = MUL_B_W'(g_ff);
            state_in     = S_TAN_A;
         end
         S_TAN_A: begin
            sat_in   = |arg_sum[ARG_W-1:21];
            idx_in   = arg_sum[20:16];
            frac_in  = arg_sum[15:0];
            state_in = S_TAN_B;
         end
         S_TAN_B: begin
            mul_req.load = 1'b1;
            mul_req.a    = MUL_A_W'(tanh_hi - tanh_lo);
            mul_req.b    = MUL_B_W'(frac_ff);
            state_in     = S_TAN_C;
         end
         S_TAN_C: begin
            mag_in = sat_ff ? SAMPLE_W'(OUT_MAX)
                            : SAMPLE_W'(tanh_lo) + SAMPLE_W'(interp_sum[32:16]);
            if (stage_ff == LAST_STAGE) begin
               state_in = S_DONE;
            end else begin
               stage_in = stage_ff + 1'b1;
               state_in = S_ENV_A;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (neg_ff && mag_ff != '0) ? -mag_ff : mag_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         drive_ff     <= DRIVE_GAIN_RESET;
         smooth_ff    <= STAGE_SMOOTHING_RESET;
         for (int i = 0; i < STAGE_COUNT; i++) begin
            env_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_DRIVE_GAIN:      drive_ff  <= csr_wdata;
               CSR_STAGE_SMOOTHING: smooth_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (env_we) begin
            env_ff[stage_ff] <= env_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      env_cur_ff  <= env_cur_in;
      g_ff        <= g_in;
      p_ff        <= p_in;
      sat_ff      <= sat_in;
      idx_ff      <= idx_in;
      frac_ff     <= frac_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_data_ff;

   // an accepted word always starts at the first stage
   a_start_first_stage: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == S_ENV_A && stage_ff == '0))
      else $error("accepted word did not start at the first stage");

   // stage counter never runs past the cascade
   a_stage_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (stage_ff <= LAST_STAGE))
      else $error("stage counter out of range");

   // a finished word waits while the output register is still held
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp.ready) |=> (state_ff == S_DONE))
      else $error("finished word overwrote a pending result");

   // results stay inside the tanh range
   a_out_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff <= OUT_POS && rsp_data_ff >= OUT_NEG))
      else $error("result magnitude reached 1.0");

endmodule

@@ sv/etdc_mul.sv @@
// shared unsigned multiplier with registered product
module etdc_mul (
   input  logic                         clock,
   input  etdc_pkg::mul_req_type        mul_req,
   output logic [etdc_pkg::PROD_W-1:0]  prod
);
   import etdc_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (mul_req.load) begin
         prod_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ tb/tb.sv @@
// testbench for the enveloped tanh distortion cascade: predicted words checked against the rsp channel
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import etdc_pkg::*;

   localparam int STAGES          = 5;
   // accept to output register of the cascade
   localparam int CASCADE_LATENCY = 9 * STAGES + 1;
   localparam int PHASE_WORDS     = 144;
   localparam int RANDOM_PHASES   = 8;
   localparam int LONG_HOLD       = 400;

   // own copy of the fibonacci ratios, unsigned q2.14
   localparam bit [15:0] FIB_RATIO_Q14 [16] = '{
      16'd26504, 16'd26512, 16'd26509, 16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510,
      16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510, 16'd26510
   };

   // own copy of the tanh breakpoints over [0,4], q.19
   localparam bit [18:0] TANH_Q19 [33] = '{
      19'd0,      19'd65197,  19'd128408, 19'd187882, 19'd242282, 19'd290770,
      19'd333001, 19'd369049, 19'd399295, 19'd424307, 19'd444745, 19'd461283,
      19'd474558, 19'd485148, 19'd493552, 19'd500194, 19'd505428, 19'd509541,
      19'd512767, 19'd515294, 19'd517270, 19'd518814, 19'd520020, 19'd520961,
      19'd521695, 19'd522268, 19'd522714, 19'd523062, 19'd523333, 19'd523544,
      19'd523708, 19'd523837, 19'd523936
   };

   localparam bit [63:0] TANH_SAT_ARG = 64'd2097152;   // 4.0 in q.19
   localparam bit [63:0] TANH_SAT_MAG = 64'd524287;    // just below 1.0

   // tracks the cascade: per-stage envelopes, register copies, words still owed
   class distortion_tracker;
      bit [23:0]  envelope [STAGES];
      bit [15:0]  drive;
      bit [15:0]  smooth;
      sample_type owed_words [$];
      int         failures;
      int         words_seen;

      function new();
         foreach (envelope[k]) envelope[k] = '0;
         drive       = 16'd8192;
         smooth      = 16'd65470;
         failures    = 0;
         words_seen  = 0;
      endfunction

      function void set_reg(input logic [CSR_ADDR_W-1:0] idx, input bit [15:0] value);
         if (idx == CSR_DRIVE_GAIN) begin
            drive = value;
         end else if (idx == CSR_STAGE_SMOOTHING) begin
            smooth = value;
         end
      endfunction

      function bit [63:0] tanh_mag(input bit [63:0] arg);
         bit [63:0] i, f, lo, hi;
         if (arg >= TANH_SAT_ARG) return TANH_SAT_MAG;
         i  = arg >> 16;
         f  = arg & 64'hFFFF;
         lo = TANH_Q19[i];
         hi = TANH_Q19[i+1];
         return lo + (((hi - lo) * f + 64'd32768) >> 16);
      endfunction

      // one word through all stages, envelopes updated on the way
      function sample_type distort(input sample_type x);
         bit [63:0] mag, c, env, g, p, arg;
         bit        neg;
         neg = x[SAMPLE_W-1];
         // most negative word falls out as 2^23, which still fits the envelope
         mag = neg ? (64'h1000000 - {40'b0, x}) : {40'b0, x};
         c   = {48'b0, smooth};
         for (int k = 0; k < STAGES; k++) begin
            env = (c * envelope[k] + (64'd65536 - c) * mag + 64'd32768) >> 16;
            envelope[k] = env[23:0];
            g   = ({48'b0, drive} * FIB_RATIO_Q14[k % 16] + 64'd8192) >> 14;
            p   = ({40'b0, envelope[k]} * mag + 64'd262144) >> 19;
            arg = (g * p + 64'd4096) >> 13;
            mag = tanh_mag(arg);
         end
         // sign goes back on last, a zero magnitude stays zero
         if (neg && mag != 0) return sample_type'(24'h0 - mag[23:0]);
         return sample_type'(mag[23:0]);
      endfunction

      function void note_sample(input sample_type x);
         owed_words.push_back(distort(x));
      endfunction

      function void check_word(input sample_type y);
         sample_type want;
         words_seen++;
         if (owed_words.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected rsp word %0d: got %0d", words_seen, y);
            return;
         end
         want = owed_words.pop_front();
         if (want !== y) begin
            failures++;
            if (failures <= 10)
               $display("rsp word %0d mismatch: expected %0d got %0d", words_seen, want, y);
         end
      endfunction

      function int pending();
         return owed_words.size();
      endfunction

      function void finish_check();
         if (owed_words.size() != 0) begin
            failures++;
            $display("%0d expected rsp words never arrived", owed_words.size());
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [COEF_W-1:0]     csr_wdata;

   etdc_req_if req_ch();
   etdc_rsp_if rsp_ch();

   distortion_tracker tracker;

   int burst_left;
   int hold_left;     // long receiver hold-off, set by the stimulus, run down by the receiver

   enveloped_tanh_distortion_cascade #(
      .STAGE_COUNT(STAGES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // every accepted req word gets its prediction queued
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         tracker.note_sample(req_ch.sample_in);
      end
   end

   // every accepted rsp word is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.check_word(rsp_ch.sample_out);
      end
   end

   // receiver: changes its stall pattern now and then, and honors a long hold-off
   initial begin : receiver
      int        mode_left;
      int        mode;
      bit [15:0] pattern;
      mode_left   = 0;
      mode        = 0;
      pattern     = '1;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(50, 400);
               mode      = $urandom_range(0, 3);
               pattern   = 16'($urandom);
            end
            mode_left--;
            case (mode)
               0: begin
                  // no stalls at all
                  rsp_ch.ready <= 1'b1;
               end
               1: begin
                  rsp_ch.ready <= 1'($urandom);
               end
               2: begin
                  // fixed rotating pattern
                  rsp_ch.ready <= pattern[0];
                  pattern = {pattern[0], pattern[15:1]};
               end
               default: begin
                  // mostly stalled
                  rsp_ch.ready <= ($urandom_range(0, 7) == 0);
               end
            endcase
         end
      end
   end

   // register write, only called while the block is idle
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [COEF_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      tracker.set_reg(idx, value);
   endtask

   task automatic set_drive_smooth(input logic [COEF_W-1:0] drive, input logic [COEF_W-1:0] smooth);
      write_csr(CSR_DRIVE_GAIN, drive);
      write_csr(CSR_STAGE_SMOOTHING, smooth);
   endtask

   // offers one word and waits for the handshake; bursts end in a random gap
   task automatic send_word(input sample_type s);
      int gap;
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= s;
      do @(posedge clock); while (!req_ch.ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 30);
         gap        = $urandom_range(1, 20);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // stop offering, wait for every owed word, then let the pipeline settle
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (CASCADE_LATENCY + 8) @(posedge clock);
   endtask

   // mix of full range, small, around unity and corner words
   function automatic sample_type pick_sample();
      int v;
      case ($urandom_range(0, 3))
         0: return sample_type'($urandom);
         1: begin
            v = $urandom_range(0, 8191);
            return sample_type'(v - 4096);
         end
         2: begin
            v = $urandom_range(0, 1048576);
            return sample_type'(v - 524288);
         end
         default: begin
            case ($urandom_range(0, 5))
               0: return sample_type'(24'h7FFFFF);
               1: return sample_type'(24'h800000);
               2: return sample_type'(24'h000000);
               3: return sample_type'(24'hFFFFFF);
               4: return sample_type'(24'h000001 << $urandom_range(0, 23));
               default: return sample_type'(~(24'h000001 << $urandom_range(0, 23)));
            endcase
         end
      endcase
   endfunction

   initial begin : stimulus
      logic [COEF_W-1:0] phase_drive [RANDOM_PHASES];
      logic [COEF_W-1:0] phase_smooth [RANDOM_PHASES];

      tracker          = new();
      burst_left       = 0;
      hold_left        = 0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_addr         = '0;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.sample_in = '0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // reset settings: full scale words, unity, most negative word
      send_word(sample_type'(24'h000000));
      send_word(sample_type'(24'h7FFFFF));
      send_word(sample_type'(24'h800000));
      send_word(sample_type'(24'hFFFFFF));
      send_word(sample_type'(24'h000001));
      send_word(sample_type'(24'd524288));
      send_word(-sample_type'(24'd524288));
      send_word(sample_type'(24'd4194304));
      wait_idle();

      // instant envelope and drive past its range: large argument saturates both ways
      set_drive_smooth(16'hFFFF, 16'h0000);
      send_word(sample_type'(24'h7FFFFF));
      send_word(sample_type'(24'h800000));
      send_word(sample_type'(24'h000001));
      send_word(sample_type'(24'hFFFFFF));
      send_word(sample_type'(24'd100000));
      send_word(-sample_type'(24'd100000));
      send_word(sample_type'(24'h000000));
      wait_idle();

      // zero drive: negative words must come back as plain zero
      set_drive_smooth(16'h0000, 16'hFFFF);
      send_word(sample_type'(24'h7FFFFF));
      send_word(sample_type'(24'h800000));
      send_word(-sample_type'(24'd3000));
      wait_idle();

      // lowest stated drive, interpolation away from saturation
      set_drive_smooth(16'd819, 16'h0000);
      send_word(sample_type'(24'd262144));
      send_word(-sample_type'(24'd262144));
      send_word(sample_type'(24'd600000));
      send_word(-sample_type'(24'd1500000));
      wait_idle();

      phase_drive[0]  = 16'd8192;                    phase_smooth[0] = 16'd65470;
      phase_drive[1]  = 16'd32768;                   phase_smooth[1] = 16'd0;
      phase_drive[2]  = 16'd819;                     phase_smooth[2] = 16'd65535;
      phase_drive[3]  = 16'd65535;                   phase_smooth[3] = 16'd30000;
      phase_drive[4]  = 16'd0;                       phase_smooth[4] = 16'd1;
      phase_drive[5]  = 16'($urandom);               phase_smooth[5] = 16'($urandom);
      phase_drive[6]  = 16'd16384;                   phase_smooth[6] = 16'd65000;
      phase_drive[7]  = 16'($urandom_range(819, 32768));
      phase_smooth[7] = 16'($urandom);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_drive_smooth(phase_drive[ph], phase_smooth[ph]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // long receiver hold-off while words keep coming, fills the block
            if ((ph == 1 || ph == 5) && n == PHASE_WORDS / 2) begin
               hold_left = LONG_HOLD;
            end
            send_word(pick_sample());
         end
         wait_idle();
      end

      tracker.finish_check();
      if (tracker.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/etdc_pkg.sv
sv/etdc_channels.sv
sv/etdc_mul.sv
sv/enveloped_tanh_distortion_cascade.sv
tb/tb.sv
